FILE: hw/rtl/rnmst_pkg.sv
// Shared types, constants and helpers for the range-negate max-subarray tree.
package rnmst_pkg;

  // Tree geometry: a power-of-two leaf count, heap-ordered nodes 1 .. 2*LEN-1
  localparam int LOG_LEN   = 10;
  localparam int ARRAY_LEN = 1 << LOG_LEN;
  localparam int NODE_CNT  = 2 * ARRAY_LEN;
  localparam int NODE_AW   = LOG_LEN + 1;
  localparam int POS_W     = LOG_LEN + 2;
  localparam int LVL_W     = $clog2(LOG_LEN + 1);

  // Field widths
  localparam int IDX_W  = 10;
  localparam int LOAD_W = 32;
  localparam int VAL_W  = 48;

  // Function codes
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_NEGATE = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  typedef logic signed [VAL_W-1:0] val_t;

  // Aggregate of one node's range; the empty subarray counts as zero
  typedef struct packed {
    val_t sum;
    val_t pmax;
    val_t pmin;
    val_t smax;
    val_t smin;
    val_t imax;
    val_t imin;
  } rec_t;

  // Stored node word: aggregate plus pending-negate mark
  typedef struct packed {
    logic pend;
    rec_t rec;
  } node_t;

  function automatic val_t vmax(input val_t a, input val_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic val_t vmin(input val_t a, input val_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

FILE: hw/rtl/range_negate_max_subarray_tree_unit.sv
// Top level: sequencer over the node memory and the shared combine unit.
//
//  channel   dir  signals                                              word
//  item      in   item_valid/item_ready, func, range_low, range_high,  one op
//                 load_value, carry_in, reverse_read
//  result    out  result_valid/result_ready, best_sum, carry_out       one reply
//
// After reset the node memory is swept to zero, one node a cycle, all 2048 nodes,
// with item_ready low. Each word then runs push-down, body and pull-up passes
// over the two boundary paths of the tree: push-down pushes pending negates
// down along each path, the body walks the covered nodes level by level, and
// pull-up (load and negate only) rebuilds the path nodes; a query ends with a
// final combine instead, and an unused function code skips all passes.
// item_ready is high only between words. A finished reply waits in the output
// register while the next word is taken; the next reply then holds the
// sequencer until result_ready frees the output register.
module range_negate_max_subarray_tree_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic [1:0]                 func,
  input  logic [rnmst_pkg::IDX_W-1:0] range_low,
  input  logic [rnmst_pkg::IDX_W-1:0] range_high,
  input  logic signed [rnmst_pkg::LOAD_W-1:0] load_value,
  input  logic signed [rnmst_pkg::VAL_W-1:0]  carry_in,
  input  logic                       reverse_read,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic signed [rnmst_pkg::VAL_W-1:0]  best_sum,
  output logic signed [rnmst_pkg::VAL_W-1:0]  carry_out
);
  import rnmst_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_PUSH  = 7'b0000100,
    S_BODY  = 7'b0001000,
    S_PULL  = 7'b0010000,
    S_FINAL = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  localparam val_t VMAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VMIN = {1'b1, {(VAL_W-1){1'b0}}};

  state_t state;
  logic [1:0] step;
  logic side;
  logic [LVL_W-1:0] lvl;
  logic [NODE_AW-1:0] clr;
  logic [1:0] op;
  logic rev;
  val_t carry;
  rec_t leaf;
  logic [POS_W-1:0] l0, r0, l, r;
  rec_t sml, smr, a_rec, agg;
  val_t res_best, res_carry;

  // memory and combine unit hookup
  logic we;
  logic [NODE_AW-1:0] waddr, raddr;
  node_t wdata, rd;
  rec_t cmb_x, cmb_y, cmb_z;

  rnmst_node_store u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd)
  );

  rnmst_combine u_combine (.x(cmb_x), .y(cmb_y), .z(cmb_z));

  function automatic node_t flip(input node_t n);
    node_t f;
    f.pend     = ~n.pend;
    f.rec.sum  = -n.rec.sum;
    f.rec.pmax = -n.rec.pmin;
    f.rec.pmin = -n.rec.pmax;
    f.rec.smax = -n.rec.smin;
    f.rec.smin = -n.rec.smax;
    f.rec.imax = -n.rec.imin;
    f.rec.imin = -n.rec.imax;
    return f;
  endfunction

  function automatic val_t sat(input logic signed [VAL_W:0] v);
    if (v[VAL_W] != v[VAL_W-1]) begin
      return v[VAL_W] ? VMIN : VMAX;
    end
    return v[VAL_W-1:0];
  endfunction

  // boundary-path node for the current level and side
  logic [POS_W-1:0] lvl_mask, pos_sel, path_pos;
  logic [NODE_AW-1:0] node_u, child_a, child_b, body_addr;
  logic on_edge;
  logic [POS_W-1:0] r_dec;

  assign r_dec    = r - POS_W'(1);
  assign lvl_mask = (POS_W'(1) << lvl) - POS_W'(1);
  assign pos_sel  = side ? (r0 - POS_W'(1)) : l0;
  assign path_pos = pos_sel >> lvl;
  assign node_u   = path_pos[NODE_AW-1:0];
  assign child_a  = {node_u[NODE_AW-2:0], 1'b0};
  assign child_b  = {node_u[NODE_AW-2:0], 1'b1};
  assign on_edge  = side ? (|(r0 & lvl_mask)) : (|(l0 & lvl_mask));
  assign body_addr = side ? r_dec[NODE_AW-1:0] : l[NODE_AW-1:0];

  assign item_ready = (state == S_IDLE);

  // input decode: ordered endpoints and the leaf word of a load
  logic [IDX_W-1:0] lo, hi;
  val_t lv;
  rec_t leaf_in;
  assign lo = (range_low < range_high) ? range_low : range_high;
  assign hi = (range_low < range_high) ? range_high : range_low;
  assign lv = {{(VAL_W-LOAD_W){load_value[LOAD_W-1]}}, load_value};
  always_comb begin
    leaf_in.sum  = lv;
    leaf_in.pmax = lv[VAL_W-1] ? '0 : lv;
    leaf_in.smax = lv[VAL_W-1] ? '0 : lv;
    leaf_in.imax = lv[VAL_W-1] ? '0 : lv;
    leaf_in.pmin = lv[VAL_W-1] ? lv : '0;
    leaf_in.smin = lv[VAL_W-1] ? lv : '0;
    leaf_in.imin = lv[VAL_W-1] ? lv : '0;
  end

  // reply arithmetic with one guard bit, then saturation
  logic signed [VAL_W:0] carry_x, pre_x, post_x, sum_x, in_x, best_w, co_w;
  assign carry_x = {carry[VAL_W-1], carry};
  assign pre_x   = rev ? {agg.smax[VAL_W-1], agg.smax} : {agg.pmax[VAL_W-1], agg.pmax};
  assign post_x  = rev ? {agg.pmax[VAL_W-1], agg.pmax} : {agg.smax[VAL_W-1], agg.smax};
  assign sum_x   = {agg.sum[VAL_W-1], agg.sum};
  assign in_x    = {agg.imax[VAL_W-1], agg.imax};
  always_comb begin
    best_w = carry_x + pre_x;
    if (in_x > best_w) begin
      best_w = in_x;
    end
    co_w = carry_x + sum_x;
    if (post_x > co_w) begin
      co_w = post_x;
    end
  end

  // phase advance conditions
  logic push_adv, pull_adv;
  assign push_adv = (state == S_PUSH) &&
                    ((step == 2'd0 && !on_edge) || (step == 2'd1 && !rd.pend) ||
                     step == 2'd3);
  assign pull_adv = (state == S_PULL) &&
                    ((step == 2'd0 && !on_edge) || step == 2'd2);

  // memory ports and combine operands
  always_comb begin
    we    = 1'b0;
    waddr = node_u;
    wdata = '0;
    raddr = node_u;
    cmb_x = a_rec;
    cmb_y = rd.rec;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr;
      end
      S_PUSH: begin
        case (step)
          2'd1: begin
            raddr = child_a;
            if (rd.pend) begin
              we    = 1'b1;
              wdata = {1'b0, rd.rec};
            end
          end
          2'd2: begin
            raddr = child_b;
            we    = 1'b1;
            waddr = child_a;
            wdata = flip(rd);
          end
          2'd3: begin
            we    = 1'b1;
            waddr = child_b;
            wdata = flip(rd);
          end
          default: raddr = node_u;
        endcase
      end
      S_PULL: begin
        case (step)
          2'd0: raddr = child_a;
          2'd1: raddr = child_b;
          2'd2: begin
            we    = 1'b1;
            wdata = {1'b0, cmb_z};
          end
          default: raddr = node_u;
        endcase
      end
      S_BODY: begin
        raddr = body_addr;
        waddr = body_addr;
        cmb_x = side ? rd.rec : sml;
        cmb_y = side ? smr : rd.rec;
        if (step == 2'd0 && op == FUNC_LOAD) begin
          if (side ? r[0] : (l[0] && l < r)) begin
            we    = 1'b1;
            wdata = {1'b0, leaf};
          end
        end
        if (step == 2'd1 && op == FUNC_NEGATE) begin
          we    = 1'b1;
          wdata = flip(rd);
        end
      end
      S_FINAL: begin
        cmb_x = sml;
        cmb_y = smr;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr          <= '0;
      step         <= '0;
      side         <= 1'b0;
      lvl          <= '0;
      result_valid <= 1'b0;
    end else begin
      // the done state sets the output register itself
      if (result_valid && result_ready && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + NODE_AW'(1);
          if (&clr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            op        <= func;
            carry     <= carry_in;
            rev       <= reverse_read;
            leaf      <= leaf_in;
            sml       <= '0;
            smr       <= '0;
            res_best  <= '0;
            res_carry <= '0;
            lvl       <= LVL_W'(LOG_LEN);
            side      <= 1'b0;
            step      <= '0;
            if (func == FUNC_LOAD) begin
              l0 <= POS_W'(ARRAY_LEN) + POS_W'(range_low);
              r0 <= POS_W'(ARRAY_LEN) + POS_W'(range_low) + POS_W'(1);
            end else begin
              l0 <= POS_W'(ARRAY_LEN) + POS_W'(lo);
              r0 <= POS_W'(ARRAY_LEN) + POS_W'(hi) + POS_W'(1);
            end
            if (func inside {FUNC_LOAD, FUNC_NEGATE, FUNC_QUERY}) begin
              state <= S_PUSH;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_PUSH: begin
          if (push_adv) begin
            step <= '0;
            side <= ~side;
            if (side) begin
              if (lvl == LVL_W'(1)) begin
                state <= S_BODY;
                l     <= l0;
                r     <= r0;
              end else begin
                lvl <= lvl - LVL_W'(1);
              end
            end
          end else begin
            step <= step + 2'd1;
          end
        end
        S_BODY: begin
          case (step)
            2'd0: begin
              if (!side) begin
                if (l >= r) begin
                  if (op == FUNC_QUERY) begin
                    state <= S_FINAL;
                  end else begin
                    state <= S_PULL;
                    lvl   <= LVL_W'(1);
                  end
                end else if (l[0]) begin
                  if (op == FUNC_LOAD) begin
                    l    <= l + POS_W'(1);
                    side <= 1'b1;
                  end else begin
                    step <= 2'd1;
                  end
                end else begin
                  side <= 1'b1;
                end
              end else if (r[0]) begin
                if (op == FUNC_LOAD) begin
                  r    <= r_dec;
                  step <= 2'd2;
                end else begin
                  step <= 2'd1;
                end
              end else begin
                step <= 2'd2;
              end
            end
            2'd1: begin
              if (!side) begin
                l    <= l + POS_W'(1);
                side <= 1'b1;
                step <= 2'd0;
                if (op == FUNC_QUERY) begin
                  sml <= cmb_z;
                end
              end else begin
                r    <= r_dec;
                step <= 2'd2;
                if (op == FUNC_QUERY) begin
                  smr <= cmb_z;
                end
              end
            end
            default: begin
              l    <= l >> 1;
              r    <= r >> 1;
              side <= 1'b0;
              step <= 2'd0;
            end
          endcase
        end
        S_PULL: begin
          if (step == 2'd1) begin
            a_rec <= rd.rec;
          end
          if (pull_adv) begin
            step <= '0;
            side <= ~side;
            if (side) begin
              if (lvl == LVL_W'(LOG_LEN)) begin
                state <= S_DONE;
              end else begin
                lvl <= lvl + LVL_W'(1);
              end
            end
          end else begin
            step <= step + 2'd1;
          end
        end
        S_FINAL: begin
          if (step == 2'd0) begin
            agg  <= cmb_z;
            step <= 2'd1;
          end else begin
            res_best  <= sat(best_w);
            res_carry <= sat(co_w);
            step      <= 2'd0;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            best_sum     <= res_best;
            carry_out    <= res_carry;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/rnmst_node_store.sv
// Node memory: one write port, one registered read port.
module rnmst_node_store (
  input  logic                     clk,
  input  logic                     we,
  input  logic [rnmst_pkg::NODE_AW-1:0] waddr,
  input  rnmst_pkg::node_t         wdata,
  input  logic [rnmst_pkg::NODE_AW-1:0] raddr,
  output rnmst_pkg::node_t         rdata
);
  import rnmst_pkg::*;

  node_t mem [NODE_CNT];

  // write, and registered read (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/rnmst_combine.sv
// Shared combine unit: joins the aggregates of a left and a right range.
module rnmst_combine (
  input  rnmst_pkg::rec_t x,
  input  rnmst_pkg::rec_t y,
  output rnmst_pkg::rec_t z
);
  import rnmst_pkg::*;

  // x covers the lower indexes, y the upper ones
  always_comb begin
    z.sum  = x.sum + y.sum;
    z.pmax = vmax(x.pmax, x.sum + y.pmax);
    z.pmin = vmin(x.pmin, x.sum + y.pmin);
    z.smax = vmax(y.smax, x.smax + y.sum);
    z.smin = vmin(y.smin, x.smin + y.sum);
    z.imax = vmax(vmax(x.imax, y.imax), x.smax + y.pmax);
    z.imin = vmin(vmin(x.imin, y.imin), x.smin + y.pmin);
  end

endmodule

FILE: verif/range_negate_max_subarray_tree_unit_test.sv
// Testbench for the range-negate max-subarray tree unit: directed, random and stall tests.
module range_negate_max_subarray_tree_unit_test;
  import rnmst_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int LEAF_LAST = ARRAY_LEN - 1;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD = 700;
  localparam longint SAT_HI = 64'sd140737488355327;
  localparam longint SAT_LO = -64'sd140737488355328;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  logic [1:0] func = FUNC_LOAD;
  logic [IDX_W-1:0] range_low = '0;
  logic [IDX_W-1:0] range_high = '0;
  logic signed [LOAD_W-1:0] load_value = '0;
  logic signed [VAL_W-1:0] carry_in = '0;
  logic reverse_read = 1'b0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic signed [VAL_W-1:0] best_sum;
  logic signed [VAL_W-1:0] carry_out;

  range_negate_max_subarray_tree_unit u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .func(func), .range_low(range_low), .range_high(range_high),
    .load_value(load_value), .carry_in(carry_in), .reverse_read(reverse_read),
    .result_valid(result_valid), .result_ready(result_ready),
    .best_sum(best_sum), .carry_out(carry_out)
  );

  always #1 clk = ~clk;

  // Shadow segment tree, full 64-bit intermediates
  longint t_sum[2*NODE_CNT];
  longint t_pmax[2*NODE_CNT];
  longint t_pmin[2*NODE_CNT];
  longint t_smax[2*NODE_CNT];
  longint t_smin[2*NODE_CNT];
  longint t_imax[2*NODE_CNT];
  longint t_imin[2*NODE_CNT];
  bit t_pend[2*NODE_CNT];

  val_t want_best[$];
  val_t want_carry[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_long = 1'b0;

  function automatic longint lmax(longint a, longint b);
    return a > b ? a : b;
  endfunction

  function automatic longint lmin(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic void flip_node(int u);
    longint t;
    t_sum[u] = -t_sum[u];
    t = t_pmax[u]; t_pmax[u] = -t_pmin[u]; t_pmin[u] = -t;
    t = t_smax[u]; t_smax[u] = -t_smin[u]; t_smin[u] = -t;
    t = t_imax[u]; t_imax[u] = -t_imin[u]; t_imin[u] = -t;
    t_pend[u] = !t_pend[u];
  endfunction

  function automatic void spread_flip(int u);
    if (t_pend[u]) begin
      flip_node(2*u);
      flip_node(2*u+1);
      t_pend[u] = 1'b0;
    end
  endfunction

  function automatic void pull_up(int u);
    int a;
    int b;
    a = 2*u;
    b = 2*u + 1;
    t_sum[u]  = t_sum[a] + t_sum[b];
    t_pmax[u] = lmax(t_pmax[a], t_sum[a] + t_pmax[b]);
    t_pmin[u] = lmin(t_pmin[a], t_sum[a] + t_pmin[b]);
    t_smax[u] = lmax(t_smax[b], t_smax[a] + t_sum[b]);
    t_smin[u] = lmin(t_smin[b], t_smin[a] + t_sum[b]);
    t_imax[u] = lmax(lmax(t_imax[a], t_imax[b]), t_smax[a] + t_pmax[b]);
    t_imin[u] = lmin(lmin(t_imin[a], t_imin[b]), t_smin[a] + t_pmin[b]);
  endfunction

  function automatic void tree_load(int u, int l, int r, int idx, longint v);
    int mid;
    if (l == r) begin
      t_sum[u] = v;
      t_pmax[u] = lmax(0, v); t_smax[u] = lmax(0, v); t_imax[u] = lmax(0, v);
      t_pmin[u] = lmin(0, v); t_smin[u] = lmin(0, v); t_imin[u] = lmin(0, v);
      t_pend[u] = 1'b0;
      return;
    end
    spread_flip(u);
    mid = (l + r) >> 1;
    if (idx <= mid) tree_load(2*u, l, mid, idx, v);
    else tree_load(2*u+1, mid+1, r, idx, v);
    pull_up(u);
  endfunction

  function automatic void tree_negate(int u, int l, int r, int ql, int qr);
    int mid;
    if (l == ql && r == qr) begin
      flip_node(u);
      return;
    end
    spread_flip(u);
    mid = (l + r) >> 1;
    if (qr <= mid) tree_negate(2*u, l, mid, ql, qr);
    else if (ql > mid) tree_negate(2*u+1, mid+1, r, ql, qr);
    else begin
      tree_negate(2*u, l, mid, ql, mid);
      tree_negate(2*u+1, mid+1, r, mid+1, qr);
    end
    pull_up(u);
  endfunction

  function automatic longint tree_query(int u, int l, int r, int ql, int qr,
                                        inout longint carry, input bit rev);
    int mid;
    longint a;
    longint b;
    longint best;
    if (l == ql && r == qr) begin
      if (rev) begin
        best = lmax(t_imax[u], carry + t_smax[u]);
        carry = lmax(carry + t_sum[u], t_pmax[u]);
      end else begin
        best = lmax(t_imax[u], carry + t_pmax[u]);
        carry = lmax(carry + t_sum[u], t_smax[u]);
      end
      return best;
    end
    spread_flip(u);
    mid = (l + r) >> 1;
    if (qr <= mid) return tree_query(2*u, l, mid, ql, qr, carry, rev);
    if (ql > mid) return tree_query(2*u+1, mid+1, r, ql, qr, carry, rev);
    if (!rev) begin
      a = tree_query(2*u, l, mid, ql, mid, carry, rev);
      b = tree_query(2*u+1, mid+1, r, mid+1, qr, carry, rev);
    end else begin
      a = tree_query(2*u+1, mid+1, r, mid+1, qr, carry, rev);
      b = tree_query(2*u, l, mid, ql, mid, carry, rev);
    end
    return lmax(a, b);
  endfunction

  function automatic val_t clamp48(longint v);
    if (v > SAT_HI) v = SAT_HI;
    if (v < SAT_LO) v = SAT_LO;
    return val_t'(v);
  endfunction

  // Apply one accepted word to the shadow tree and queue its reply
  function automatic void predict_word(logic [1:0] f, int lo, int hi,
                                       longint v, longint c, bit rev);
    int t;
    longint best;
    best = 0;
    if (f == FUNC_LOAD) begin
      tree_load(1, 0, LEAF_LAST, lo, v);
    end else if (f == FUNC_NEGATE || f == FUNC_QUERY) begin
      if (lo > hi) begin
        t = lo; lo = hi; hi = t;
      end
      if (f == FUNC_NEGATE) tree_negate(1, 0, LEAF_LAST, lo, hi);
      else best = tree_query(1, 0, LEAF_LAST, lo, hi, c, rev);
    end
    if (f == FUNC_QUERY) begin
      want_best = {want_best, clamp48(best)};
      want_carry = {want_carry, clamp48(c)};
    end else begin
      want_best = {want_best, val_t'(0)};
      want_carry = {want_carry, val_t'(0)};
    end
  endfunction

  // Offer one word and hold it until accepted
  task automatic send_word(logic [1:0] f, int lo, int hi, logic signed [LOAD_W-1:0] v,
                           logic signed [VAL_W-1:0] c, bit rev);
    bit took;
    item_valid <= 1'b1;
    func <= f;
    range_low <= lo[IDX_W-1:0];
    range_high <= hi[IDX_W-1:0];
    load_value <= v;
    carry_in <= c;
    reverse_read <= rev;
    do begin
      @(negedge clk);
      took = item_ready;
      @(posedge clk);
    end while (!took);
    predict_word(f, lo, hi, longint'(v), longint'(c), rev);
  endtask

  // Random gap on the sender side
  task automatic maybe_gap();
    int n;
    if (calm || $urandom_range(3) != 0) return;
    n = $urandom_range(17, 1);
    item_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] rand_carry();
    case ($urandom_range(4))
      0: return {1'b0, {(VAL_W-1){1'b1}}};
      1: return {1'b1, {(VAL_W-1){1'b0}}};
      2: return '0;
      3: return VAL_W'({$urandom, $urandom});
      default: return VAL_W'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  function automatic logic signed [LOAD_W-1:0] rand_value();
    case ($urandom_range(3))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return $signed($urandom_range(200)) - 100;
    endcase
  endfunction

  task automatic test_directed();
    send_word(FUNC_QUERY, 0, LEAF_LAST, 0, '0, 1'b0);
    send_word(FUNC_LOAD, 0, 0, 32'sh7fffffff, '0, 1'b0);
    send_word(FUNC_LOAD, LEAF_LAST, 0, 32'sh80000000, '0, 1'b1);
    send_word(FUNC_LOAD, 5, 0, -7, '0, 1'b0);
    send_word(FUNC_LOAD, 6, 0, 9, '0, 1'b0);
    send_word(FUNC_QUERY, 0, LEAF_LAST, 0, '0, 1'b0);
    send_word(FUNC_QUERY, 0, LEAF_LAST, 0, '0, 1'b1);
    // carry near the signed limits: sums saturate
    send_word(FUNC_QUERY, 0, 10, 0, {1'b0, {(VAL_W-1){1'b1}}}, 1'b0);
    send_word(FUNC_QUERY, LEAF_LAST, 1000, 0, {1'b1, {(VAL_W-1){1'b0}}}, 1'b1);
    // swapped bounds
    send_word(FUNC_NEGATE, 600, 3, 0, '0, 1'b0);
    send_word(FUNC_QUERY, 6, 5, 0, -48'sd3, 1'b0);
    send_word(FUNC_NEGATE, 0, LEAF_LAST, 0, '0, 1'b0);
    send_word(FUNC_QUERY, 0, LEAF_LAST, 0, 48'sd11, 1'b1);
    send_word(FUNC_NEGATE, 5, 5, 0, '0, 1'b1);
    send_word(FUNC_QUERY, 5, 5, 0, '0, 1'b0);
    // unused code leaves the tree alone
    send_word(FUNC_UNUSED, LEAF_LAST, LEAF_LAST, 32'sh7fffffff, '1, 1'b1);
    send_word(FUNC_QUERY, 0, LEAF_LAST, -1, '1, 1'b0);
    send_word(FUNC_NEGATE, 511, 512, 0, '0, 1'b0);
    send_word(FUNC_QUERY, 512, 511, 0, '0, 1'b1);
  endtask

  // Mostly loads, negates and queries over a random window, with some unused codes
  task automatic random_words(int count);
    int lo;
    int hi;
    int base;
    int pick;
    logic [1:0] f;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 30) f = FUNC_LOAD;
      else if (pick < 55) f = FUNC_NEGATE;
      else if (pick < 95) f = FUNC_QUERY;
      else f = FUNC_UNUSED;
      if ($urandom_range(3) == 0) begin
        lo = $urandom_range(LEAF_LAST);
        hi = $urandom_range(LEAF_LAST);
      end else begin
        base = $urandom_range(LEAF_LAST - 40);
        lo = base + $urandom_range(40);
        hi = base + $urandom_range(40);
      end
      send_word(f, lo, hi, rand_value(), rand_carry(), 1'($urandom_range(1)));
      maybe_gap();
    end
  endtask

  task automatic test_random();
    random_words(440);
  endtask

  // Receiver holds off while words keep coming, so the input stalls
  task automatic test_backpressure();
    hold_long = 1'b1;
    random_words(20);
  endtask

  task automatic test_tail();
    calm = 1'b1;
    random_words(70);
  endtask

  // Receiver: random stalls, one long hold when asked
  initial begin : result_side
    int hold;
    hold = 0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        hold_long = 1'b0;
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (hold > 0) begin
        hold--;
        result_ready <= 1'b0;
      end else if (!calm && $urandom_range(5) == 0) begin
        hold = $urandom_range(17, 1) - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Check each reply, run the watchdog
  always @(negedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) begin
        idle_cycles <= 0;
        if (want_best.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected reply best %0d carry %0d",
                                         best_sum, carry_out);
        end else begin
          if (best_sum !== want_best[0] || carry_out !== want_carry[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("reply mismatch: best %0d/%0d carry %0d/%0d (want/got)",
                       want_best[0], best_sum, want_carry[0], carry_out);
          end
          void'(want_best.pop_front());
          void'(want_carry.pop_front());
        end
      end else if (item_valid && item_ready) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("range_negate_max_subarray_tree_unit_test NOT OK");
    $finish;
  end

  initial begin : main
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    test_backpressure();
    test_tail();
    item_valid <= 1'b0;
    wait (want_best.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("range_negate_max_subarray_tree_unit_test OK");
    end else begin
      $display("range_negate_max_subarray_tree_unit_test NOT OK");
    end
    $finish;
  end

endmodule
